FILE: rtl/bcs_pkg.sv
// Shared types and constants for the battery charge sequencer.
// Used by every module in rtl/; depends on nothing else.
package bcs_pkg;

    // Field widths
    localparam int MV_W       = 13;
    localparam int MA_W       = 18;
    localparam int CUR_W      = 19;
    localparam int SEC_W      = 16;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 8;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Queue between the front and the back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [SEC_W-1:0] SEC_MAX = {SEC_W{1'b1}};

    // Charge states
    typedef enum logic [2:0] {
        ST_DISCONNECTED = 3'd0,
        ST_CHARGING     = 3'd1,
        ST_BALANCING    = 3'd2,
        ST_SENSING      = 3'd3,
        ST_COMPLETE     = 3'd4,
        ST_FAULTED      = 3'd5
    } charge_state_t;

    // Configuration register indexes (byte address is 4 times the index)
    typedef enum logic [2:0] {
        REG_CELL_FULL_MIN = 3'd0,
        REG_CELL_FULL_MAX = 3'd1,
        REG_MIN_CURRENT   = 3'd2,
        REG_SETTLE_TIME   = 3'd3,
        REG_BALANCE_INT   = 3'd4
    } reg_index_t;

    // One classified word, as the front hands it to the back
    typedef struct packed {
        logic present;
        logic fault;
        logic left_to_charge;
        logic over_charged;
        logic nominal;
    } cls_t;

    // Timing limits used by the back
    typedef struct packed {
        logic [SEC_W-1:0] settle_time_s;
        logic [SEC_W-1:0] balance_interval_s;
    } timing_cfg_t;

endpackage

FILE: rtl/bcs_front.sv
// Front part of the charge sequencer: accepts input words and classifies
// them against the cell and current thresholds. Depends on bcs_pkg.
module bcs_front (
    // Input word, from bit 0 up: charger_present[0], lowest_cell_mv[13:1],
    // highest_cell_mv[26:14], fault_active[27], current_valid[28],
    // pack_current_ma[47:29]
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [bcs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [bcs_pkg::MV_W-1:0]       cell_full_min_mv,
    input  logic [bcs_pkg::MV_W-1:0]       cell_full_max_mv,
    input  logic [bcs_pkg::MA_W-1:0]       min_charge_current_ma,
    input  logic                           queue_full,
    output logic                           push,
    output bcs_pkg::cls_t                  cls
);
    import bcs_pkg::*;

    logic              charger_present;
    logic [MV_W-1:0]   lowest_cell_mv;
    logic [MV_W-1:0]   highest_cell_mv;
    logic              fault_active;
    logic              current_valid;
    logic [CUR_W-1:0]  pack_current_ma;
    logic [CUR_W-1:0]  current_mag;

    // Unpack the word.
    assign charger_present = s_axis_tdata[0];
    assign lowest_cell_mv  = s_axis_tdata[13:1];
    assign highest_cell_mv = s_axis_tdata[26:14];
    assign fault_active    = s_axis_tdata[27];
    assign current_valid   = s_axis_tdata[28];
    assign pack_current_ma = s_axis_tdata[47:29];

    // Magnitude of the signed current; the most negative value maps to 2^18.
    assign current_mag = pack_current_ma[CUR_W-1] ? (~pack_current_ma + 1'b1)
                                                  : pack_current_ma;

    // Threshold checks.
    always_comb begin
        cls.present        = charger_present;
        cls.fault          = fault_active;
        cls.left_to_charge = lowest_cell_mv < cell_full_min_mv;
        cls.over_charged   = highest_cell_mv > cell_full_max_mv;
        cls.nominal        = current_valid &&
                             (current_mag >= {1'b0, min_charge_current_ma});
    end

    // A word is taken whenever the queue has room.
    assign s_axis_tready = !queue_full;
    assign push          = s_axis_tvalid && !queue_full;

endmodule

FILE: rtl/bcs_queue.sv
// Short queue of classified words between the front and the back.
// Depends on bcs_pkg.
module bcs_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  bcs_pkg::cls_t  push_data,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output bcs_pkg::cls_t  head
);
    import bcs_pkg::*;

    cls_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/bcs_back.sv
// Back part of the charge sequencer: runs the state machine on each
// classified word and holds the result word. Depends on bcs_pkg.
module bcs_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            queue_not_empty,
    input  bcs_pkg::cls_t                   head,
    output logic                            pop,
    input  bcs_pkg::timing_cfg_t            timing_cfg,
    // Result word, from bit 0 up: charge_state[2:0], charge_req[3],
    // balance_en[4], close_contactors[5], send_charger_frame[6],
    // soc_reset[7]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [bcs_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import bcs_pkg::*;

    charge_state_t                state_reg;
    charge_state_t                state_next;
    charge_state_t                handled_state;
    logic [SEC_W-1:0]             seconds_reg;
    logic [SEC_W-1:0]             seconds_next;
    logic [SEC_W-1:0]             seconds_handled;
    logic                         moved;
    logic                         charge_req;
    logic                         balance_en;
    logic                         close_contactors;
    logic                         out_valid_reg;
    logic [OUT_DATA_W-1:0]        out_data_reg;
    logic [OUT_DATA_W-1:0]        out_data_next;

    // A word is executed when the output register is free or being emptied.
    assign pop = queue_not_empty && (!out_valid_reg || m_axis_tready);

    // Overrides: a fault forces faulted, a lost charger forces disconnected.
    always_comb begin
        handled_state   = state_reg;
        seconds_handled = seconds_reg;
        if (state_reg != ST_FAULTED && head.fault) begin
            handled_state   = ST_FAULTED;
            seconds_handled = '0;
        end else if (state_reg != ST_DISCONNECTED && !head.present) begin
            handled_state   = ST_DISCONNECTED;
            seconds_handled = '0;
        end
    end

    // Next state from the handled state.
    always_comb begin
        state_next = handled_state;
        case (handled_state)
            ST_DISCONNECTED: begin
                if (head.present) begin
                    state_next = ST_BALANCING;
                end
            end
            ST_CHARGING: begin
                if (head.over_charged) begin
                    state_next = ST_BALANCING;
                end else if (!head.left_to_charge) begin
                    state_next = ST_COMPLETE;
                end else if (!head.nominal &&
                             seconds_handled >= timing_cfg.settle_time_s) begin
                    state_next = ST_COMPLETE;
                end
            end
            ST_BALANCING: begin
                if (!head.left_to_charge) begin
                    state_next = ST_COMPLETE;
                end else if (!head.over_charged) begin
                    state_next = ST_CHARGING;
                end else if (seconds_handled >= timing_cfg.balance_interval_s) begin
                    state_next = ST_SENSING;
                end
            end
            ST_SENSING: begin
                if (seconds_handled != '0) begin
                    state_next = ST_BALANCING;
                end
            end
            default: begin
                state_next = handled_state;
            end
        endcase
    end

    // Drive outputs follow the handled state.
    always_comb begin
        charge_req       = 1'b0;
        balance_en       = 1'b0;
        close_contactors = 1'b0;
        case (handled_state)
            ST_CHARGING: begin
                charge_req       = 1'b1;
                close_contactors = 1'b1;
            end
            ST_BALANCING: begin
                balance_en       = 1'b1;
                close_contactors = 1'b1;
            end
            ST_SENSING: begin
                close_contactors = 1'b1;
            end
            default: begin
                charge_req       = 1'b0;
            end
        endcase
    end

    // Seconds count restarts at one on entry, then counts up by one, saturating.
    assign moved = (state_next != handled_state);
    always_comb begin
        if (moved) begin
            seconds_next = SEC_W'(1);
        end else if (seconds_handled != SEC_MAX) begin
            seconds_next = seconds_handled + 1'b1;
        end else begin
            seconds_next = seconds_handled;
        end
    end

    // Result word packing.
    always_comb begin
        out_data_next = {
            moved && (state_next == ST_COMPLETE),
            state_next != ST_DISCONNECTED,
            close_contactors,
            balance_en,
            charge_req,
            state_next
        };
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_DISCONNECTED;
            seconds_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                state_reg   <= state_next;
                seconds_reg <= seconds_next;
            end
            if (pop) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge aclk) begin
        if (pop) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

FILE: rtl/battery_charge_sequencer.sv
// Battery charge sequencer top level: APB registers, front, queue, back.
// Path: an accepted word is written into the queue, then its result word into the output register.
// Throughput: one word per cycle while the result port is not held.
// Stalls: a held result port fills the two-entry queue and the output register,
// then s_axis_tready drops until the edge at which a result word is taken.
// Reset: synchronous, active low; clears state, queue and valid, loads defaults.
module battery_charge_sequencer (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input word, from bit 0 up: charger_present[0], lowest_cell_mv[13:1],
    // highest_cell_mv[26:14], fault_active[27], current_valid[28],
    // pack_current_ma[47:29]
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [bcs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // Result word, from bit 0 up: charge_state[2:0], charge_req[3],
    // balance_en[4], close_contactors[5], send_charger_frame[6],
    // soc_reset[7]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [bcs_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bcs_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bcs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bcs_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import bcs_pkg::*;

    logic [MV_W-1:0]   cell_full_min_reg;
    logic [MV_W-1:0]   cell_full_max_reg;
    logic [MA_W-1:0]   min_current_reg;
    logic [SEC_W-1:0]  settle_time_reg;
    logic [SEC_W-1:0]  balance_int_reg;
    reg_index_t        reg_index;
    logic              cfg_write;
    logic              push;
    cls_t              front_cls;
    cls_t              queue_head;
    logic              queue_full;
    logic              queue_not_empty;
    logic              pop;
    timing_cfg_t       timing_cfg;

    // Configuration port.
    assign pready    = 1'b1;
    assign reg_index = reg_index_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_full_min_reg <= MV_W'(4150);
            cell_full_max_reg <= MV_W'(4200);
            min_current_reg   <= MA_W'(2000);
            settle_time_reg   <= SEC_W'(10);
            balance_int_reg   <= SEC_W'(60);
        end else if (cfg_write) begin
            case (reg_index)
                REG_CELL_FULL_MIN: cell_full_min_reg <= pwdata[MV_W-1:0];
                REG_CELL_FULL_MAX: cell_full_max_reg <= pwdata[MV_W-1:0];
                REG_MIN_CURRENT:   min_current_reg   <= pwdata[MA_W-1:0];
                REG_SETTLE_TIME:   settle_time_reg   <= pwdata[SEC_W-1:0];
                REG_BALANCE_INT:   balance_int_reg   <= pwdata[SEC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register read back.
    always_comb begin
        case (reg_index)
            REG_CELL_FULL_MIN: prdata = APB_DATA_W'(cell_full_min_reg);
            REG_CELL_FULL_MAX: prdata = APB_DATA_W'(cell_full_max_reg);
            REG_MIN_CURRENT:   prdata = APB_DATA_W'(min_current_reg);
            REG_SETTLE_TIME:   prdata = APB_DATA_W'(settle_time_reg);
            REG_BALANCE_INT:   prdata = APB_DATA_W'(balance_int_reg);
            default:           prdata = '0;
        endcase
    end

    assign timing_cfg.settle_time_s      = settle_time_reg;
    assign timing_cfg.balance_interval_s = balance_int_reg;

    bcs_front u_front (
        .s_axis_tvalid         (s_axis_tvalid),
        .s_axis_tready         (s_axis_tready),
        .s_axis_tdata          (s_axis_tdata),
        .cell_full_min_mv      (cell_full_min_reg),
        .cell_full_max_mv      (cell_full_max_reg),
        .min_charge_current_ma (min_current_reg),
        .queue_full            (queue_full),
        .push                  (push),
        .cls                   (front_cls)
    );

    bcs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (front_cls),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head      (queue_head)
    );

    bcs_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .queue_not_empty (queue_not_empty),
        .head            (queue_head),
        .pop             (pop),
        .timing_cfg      (timing_cfg),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata)
    );

    // A word entering complete always reports the complete state.
    a_soc_reset_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[7] |-> m_axis_tdata[2:0] == ST_COMPLETE)
        else $error("soc_reset without complete state");

    // Requesting charge always comes with closed contactors and no balancing.
    a_request_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[5] && !m_axis_tdata[4])
        else $error("charge request without contactors or with balancing");

    // The charger frame flag matches the reported state.
    a_frame_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[6] == (m_axis_tdata[2:0] != ST_DISCONNECTED))
        else $error("send_charger_frame disagrees with charge_state");

    // The queue never takes a word while full, nor pops while empty.
    a_queue_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && queue_full) && !(pop && !queue_not_empty))
        else $error("queue overflow or underflow");

endmodule
